### design/sha256_pkg.sv
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned NumRounds  = 64;
  localparam int unsigned NumHash    = 8;
  localparam int unsigned PadLimit   = 56;

  typedef logic [31:0] word_t;

  localparam word_t RoundConst [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitHash [NumHash] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### design/sha256_byte_stream_hasher_core.sv
// SHA-256 hasher over a byte stream.
// Input channel: in_valid / in_stall with in_message_byte, in_byte_valid and
// in_end_of_message. Bytes collect in a 64-byte buffer; each full block runs
// one compression of 64 rounds, one round per cycle on a single round unit,
// with the message schedule kept in a rolling 16-word window.
// Output channel: out_valid / out_stall with out_digest_word, out_word_index
// and out_last_word; an end item yields eight words, index 0 first.
// A byte that does not fill the block is absorbed in S_IDLE; a byte that
// completes a block is followed by the window load (S_LOAD), the rounds
// (S_ROUND) and the hash add (S_ADD) before the next byte is taken. An end
// item pads into the buffer one byte per cycle, compresses once or twice,
// then presents the eight words, one per cycle that the receiver does not stall.
// in_stall is high whenever the block is busy with an item.
// Reset (synchronous, rst_n low) loads the initial hash words and clears the
// bit count and fill count; the buffer contents are not cleared.
// A stall on the output holds the current word until it is taken; the next
// message is accepted once the last word is gone.
module sha256_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_message_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_ROUND, S_ADD, S_PAD, S_LEN, S_EMIT
  } state_t;

  state_t      state_r;
  word_t       buf_r [BlockBytes / 4];
  word_t       hash_r [NumHash];
  word_t       v_r [NumHash];
  word_t       w_r [16];
  logic [63:0] bits_r;
  logic [63:0] total_r;
  logic [6:0]  fill_r;
  logic [5:0]  cnt_r;
  logic        fin_r;
  logic [2:0]  idx_r;
  logic [4:0]  lane_sh;

  // Byte lane within a buffer word, first byte in the top bits
  assign lane_sh = {~fill_r[1:0], 3'd0};

  // Round datapath
  word_t s1, s0, ch, maj, t1, sig0, sig1, w_new, w_cur, rd_word;
  always_comb begin
    s1    = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    s0    = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    w_cur = w_r[0];
    t1    = v_r[7] + s1 + ch + RoundConst[cnt_r] + w_cur;
    sig0  = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    sig1  = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + sig0 + w_r[9] + sig1;
    rd_word = buf_r[cnt_r[3:0]];
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_EMIT);
  assign out_digest_word = hash_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < NumHash; i++) hash_r[i] <= InitHash[i];
      bits_r  <= '0;
      fill_r  <= '0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      case (state_r)
        // Absorb a byte; start a compression or padding as needed
        S_IDLE: begin
          if (in_valid) begin
            fin_r <= in_end_of_message;
            cnt_r <= '0;
            if (in_byte_valid) begin
              buf_r[fill_r[5:2]][lane_sh +: 8] <= in_message_byte;
              if (fill_r == 7'd63) begin
                fill_r  <= '0;
                bits_r  <= bits_r + 64'd512;
                total_r <= bits_r + 64'd512;
                state_r <= S_LOAD;
              end else begin
                fill_r  <= fill_r + 7'd1;
                total_r <= bits_r + {54'd0, fill_r + 7'd1, 3'd0};
                if (in_end_of_message) state_r <= S_PAD;
              end
            end else if (in_end_of_message) begin
              total_r <= bits_r + {54'd0, fill_r, 3'd0};
              state_r <= S_PAD;
            end
          end
        end
        // Write 0x80 then zeros up to the length field or block end
        S_PAD: begin
          buf_r[fill_r[5:2]][lane_sh +: 8] <= (cnt_r == 6'd0) ? PadByte : 8'h00;
          cnt_r <= 6'd1;
          if (fill_r == 7'd63) begin
            fill_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_LOAD;
          end else if (fill_r == 7'(PadLimit - 1)) begin
            fill_r  <= 7'(PadLimit);
            cnt_r   <= '0;
            state_r <= S_LEN;
          end else begin
            fill_r <= fill_r + 7'd1;
          end
        end
        // Write the big-endian bit count into the last eight bytes
        S_LEN: begin
          buf_r[14] <= total_r[63:32];
          buf_r[15] <= total_r[31:0];
          fill_r  <= 7'd64;
          cnt_r   <= '0;
          state_r <= S_LOAD;
        end
        // Load the schedule window and working words
        S_LOAD: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= rd_word;
          for (int i = 0; i < NumHash; i++) v_r[i] <= hash_r[i];
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd15) begin
            cnt_r   <= '0;
            state_r <= S_ROUND;
          end
        end
        // One compression round per cycle
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_new;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + s0 + maj;
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_r <= S_ADD;
        end
        // Fold into the hash; decide what follows
        S_ADD: begin
          for (int i = 0; i < NumHash; i++) hash_r[i] <= hash_r[i] + v_r[i];
          cnt_r <= '0;
          idx_r <= '0;
          if (fill_r == 7'd64) begin
            fill_r  <= '0;
            state_r <= S_EMIT;
          end else if (fin_r) begin
            // A length on a block boundary means the end byte filled the
            // block, so padding still starts with 0x80
            cnt_r   <= (total_r[8:0] == 9'd0) ? 6'd0 : 6'd1;
            state_r <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        // Present digest words; restart the message after the last
        S_EMIT: begin
          if (!out_stall) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              for (int i = 0; i < NumHash; i++) hash_r[i] <= InitHash[i];
              bits_r  <= '0;
              fill_r  <= '0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
